// ===== hw/rtl/rbs_pkg.sv =====
// Shared constants and types for the ray / box slab intersection pipeline.
// No dependencies.
`default_nettype none
package rbs_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int THR_W     = 16;
    localparam int AXES      = 3;
    localparam int LANES     = 2 * AXES;
    localparam int NUM_W     = COORD_W + 1;           // |bound - origin|
    localparam int DEN_W     = COORD_W;               // |direction|
    localparam int DVD_W     = NUM_W + FRAC_BITS;     // scaled dividend
    localparam int DIV_STEPS = DVD_W;                 // one quotient bit per stage

    localparam logic [THR_W-1:0]   THR_RESET = THR_W'(1);
    localparam logic [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [2:0] {
        MC_HIT      = 3'd0,
        MC_EMPTY    = 3'd1,
        MC_PARALLEL = 3'd2,
        MC_DISJOINT = 3'd3,
        MC_BEHIND   = 3'd4
    } miss_cause_t;

    // One restoring-division lane.
    typedef struct packed {
        logic [DVD_W-1:0]   dvd;   // dividend bits not yet consumed, MSB first
        logic [DEN_W-1:0]   rem;
        logic [DEN_W-1:0]   den;
        logic [COORD_W-1:0] quo;   // low quotient bits
        logic               ovf;   // a quotient bit fell off the top
        logic               neg;   // quotient sign
        logic               nz;    // numerator nonzero
    } lane_t;

    typedef struct packed {
        logic            empty;
        logic [AXES-1:0] par;
        logic [AXES-1:0] par_out;
    } side_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        side_t             side;
    } div_word_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ray_box_slab_intersect.sv =====
// Ray / axis-aligned box slab test, signed Q16.16, fully pipelined.
// Stages from input transaction to result: 1 prep, 49 divide, 4 resolve.
// Throughput: one transaction per cycle; each stage holds under stall, bubbles collapse.
// Depth is set by the six restoring dividers, one quotient bit per stage.
// Reset (rst_n, async, active low) empties the pipe and sets parallel_threshold to 1.
`default_nettype none
module ray_box_slab_intersect (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // threshold register write
    input  wire logic                          cfg_wr_en,
    input  wire logic [rbs_pkg::THR_W-1:0]     cfg_wr_data,
    // input transaction
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [rbs_pkg::COORD_W-1:0]   origin_x,
    input  wire logic [rbs_pkg::COORD_W-1:0]   origin_y,
    input  wire logic [rbs_pkg::COORD_W-1:0]   origin_z,
    input  wire logic [rbs_pkg::COORD_W-1:0]   dir_x,
    input  wire logic [rbs_pkg::COORD_W-1:0]   dir_y,
    input  wire logic [rbs_pkg::COORD_W-1:0]   dir_z,
    input  wire logic [rbs_pkg::COORD_W-1:0]   box_min_x,
    input  wire logic [rbs_pkg::COORD_W-1:0]   box_min_y,
    input  wire logic [rbs_pkg::COORD_W-1:0]   box_min_z,
    input  wire logic [rbs_pkg::COORD_W-1:0]   box_max_x,
    input  wire logic [rbs_pkg::COORD_W-1:0]   box_max_y,
    input  wire logic [rbs_pkg::COORD_W-1:0]   box_max_z,
    // result transaction
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               hit,
    output logic [2:0]                         miss_cause,
    output logic [rbs_pkg::COORD_W-1:0]        enter_distance,
    output logic [rbs_pkg::COORD_W-1:0]        exit_distance
);

    logic [rbs_pkg::THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= rbs_pkg::THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Pipe links: index 0 is the prep stage output, DIV_STEPS the last divide stage.
    logic               pv   [rbs_pkg::DIV_STEPS+1];
    logic               prdy [rbs_pkg::DIV_STEPS+1];
    rbs_pkg::div_word_t pw   [rbs_pkg::DIV_STEPS+1];
    logic               in_ready;

    rbs_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (thr_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .org       ({origin_z, origin_y, origin_x}),
        .dir       ({dir_z, dir_y, dir_x}),
        .lo        ({box_min_z, box_min_y, box_min_x}),
        .hi        ({box_max_z, box_max_y, box_max_x}),
        .out_valid (pv[0]),
        .out_ready (prdy[0]),
        .out_word  (pw[0])
    );

    assign in_stall = !in_ready;

    // Quotient bits are produced MSB first, one per stage.
    for (genvar k = 0; k < rbs_pkg::DIV_STEPS; k++)
    begin : g_div
        rbs_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pv[k]),
            .in_ready  (prdy[k]),
            .in_word   (pw[k]),
            .out_valid (pv[k+1]),
            .out_ready (prdy[k+1]),
            .out_word  (pw[k+1])
        );
    end

    rbs_resolve u_resolve (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (pv[rbs_pkg::DIV_STEPS]),
        .in_ready       (prdy[rbs_pkg::DIV_STEPS]),
        .in_word        (pw[rbs_pkg::DIV_STEPS]),
        .out_valid      (out_valid),
        .out_ready      (!out_stall),
        .hit            (hit),
        .miss_cause     (miss_cause),
        .enter_distance (enter_distance),
        .exit_distance  (exit_distance)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/rbs_prep.sv =====
// Front stage: slab differences, magnitudes, parallel and empty-box flags.
// Depends on rbs_pkg.
`default_nettype none
module rbs_prep (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic [rbs_pkg::THR_W-1:0]                  threshold,
    input  wire logic                                       in_valid,
    output logic                                            in_ready,
    input  wire logic [rbs_pkg::AXES-1:0][rbs_pkg::COORD_W-1:0] org,
    input  wire logic [rbs_pkg::AXES-1:0][rbs_pkg::COORD_W-1:0] dir,
    input  wire logic [rbs_pkg::AXES-1:0][rbs_pkg::COORD_W-1:0] lo,
    input  wire logic [rbs_pkg::AXES-1:0][rbs_pkg::COORD_W-1:0] hi,
    output logic                                            out_valid,
    input  wire logic                                       out_ready,
    output rbs_pkg::div_word_t                              out_word
);

    logic               v_reg;
    rbs_pkg::div_word_t word_reg;
    rbs_pkg::div_word_t word_next;

    always_comb
    begin
        logic [rbs_pkg::NUM_W-1:0] dlo;
        logic [rbs_pkg::NUM_W-1:0] dhi;
        logic [rbs_pkg::NUM_W-1:0] mlo;
        logic [rbs_pkg::NUM_W-1:0] mhi;
        logic [rbs_pkg::DEN_W-1:0] dm;
        logic                      par;
        word_next = '0;
        for (int i = 0; i < rbs_pkg::AXES; i++)
        begin
            dlo = {lo[i][rbs_pkg::COORD_W-1], lo[i]} - {org[i][rbs_pkg::COORD_W-1], org[i]};
            dhi = {hi[i][rbs_pkg::COORD_W-1], hi[i]} - {org[i][rbs_pkg::COORD_W-1], org[i]};
            mlo = dlo[rbs_pkg::NUM_W-1] ? -dlo : dlo;
            mhi = dhi[rbs_pkg::NUM_W-1] ? -dhi : dhi;
            dm  = dir[i][rbs_pkg::COORD_W-1] ? -dir[i] : dir[i];
            par = dm < {{(rbs_pkg::DEN_W-rbs_pkg::THR_W){1'b0}}, threshold};

            word_next.lane[2*i].dvd   = {mlo, {rbs_pkg::FRAC_BITS{1'b0}}};
            word_next.lane[2*i].den   = dm;
            word_next.lane[2*i].neg   = dlo[rbs_pkg::NUM_W-1] ^ dir[i][rbs_pkg::COORD_W-1];
            word_next.lane[2*i].nz    = |dlo;
            word_next.lane[2*i+1].dvd = {mhi, {rbs_pkg::FRAC_BITS{1'b0}}};
            word_next.lane[2*i+1].den = dm;
            word_next.lane[2*i+1].neg = dhi[rbs_pkg::NUM_W-1] ^ dir[i][rbs_pkg::COORD_W-1];
            word_next.lane[2*i+1].nz  = |dhi;

            word_next.side.par[i]     = par;
            word_next.side.par_out[i] = par && (($signed(org[i]) < $signed(lo[i])) ||
                                                ($signed(org[i]) > $signed(hi[i])));
            if ($signed(lo[i]) > $signed(hi[i]))
            begin
                word_next.side.empty = 1'b1;
            end
        end
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = v_reg;
    assign out_word  = word_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/rbs_div_stage.sv =====
// One restoring-division step on all six lanes, as an elastic register stage.
// Depends on rbs_pkg.
`default_nettype none
module rbs_div_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rbs_pkg::div_word_t in_word,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rbs_pkg::div_word_t      out_word
);

    logic               v_reg;
    rbs_pkg::div_word_t word_reg;
    rbs_pkg::div_word_t word_next;

    always_comb
    begin
        logic [rbs_pkg::DEN_W:0] sh;
        logic [rbs_pkg::DEN_W:0] diff;
        logic                    ge;
        word_next = in_word;
        for (int l = 0; l < rbs_pkg::LANES; l++)
        begin
            sh   = {in_word.lane[l].rem, in_word.lane[l].dvd[rbs_pkg::DVD_W-1]};
            diff = sh - {1'b0, in_word.lane[l].den};
            ge   = sh >= {1'b0, in_word.lane[l].den};
            word_next.lane[l].rem = ge ? diff[rbs_pkg::DEN_W-1:0] : sh[rbs_pkg::DEN_W-1:0];
            word_next.lane[l].dvd = {in_word.lane[l].dvd[rbs_pkg::DVD_W-2:0], 1'b0};
            word_next.lane[l].quo = {in_word.lane[l].quo[rbs_pkg::COORD_W-2:0], ge};
            word_next.lane[l].ovf = in_word.lane[l].ovf |
                                    in_word.lane[l].quo[rbs_pkg::COORD_W-1];
        end
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = v_reg;
    assign out_word  = word_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/rbs_resolve.sv =====
// Back end: saturate quotients, order slab pairs, reduce near/far, classify.
// Four elastic stages; depends on rbs_pkg.
`default_nettype none
module rbs_resolve (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire rbs_pkg::div_word_t          in_word,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             hit,
    output logic [2:0]                       miss_cause,
    output logic [rbs_pkg::COORD_W-1:0]      enter_distance,
    output logic [rbs_pkg::COORD_W-1:0]      exit_distance
);

    typedef logic [rbs_pkg::COORD_W-1:0] word_t;

    logic rdy1, rdy2, rdy3, rdy4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    word_t [rbs_pkg::LANES-1:0] t1_reg, t1_next;
    rbs_pkg::side_t             side1_reg, side2_reg, side3_reg;
    word_t [rbs_pkg::AXES-1:0]  n2_reg, n2_next, f2_reg, f2_next;
    word_t                      n3_reg, n3_next, f3_reg, f3_next;
    rbs_pkg::miss_cause_t       cause_next;
    logic                       hit_reg;
    logic [2:0]                 cause_reg;
    word_t                      enter_reg, exit_reg;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // saturate to the signed range, apply sign; a zero numerator gives zero
    always_comb
    begin
        word_t lim;
        word_t qs;
        for (int l = 0; l < rbs_pkg::LANES; l++)
        begin
            lim = in_word.lane[l].neg ? rbs_pkg::T_MIN : rbs_pkg::T_MAX;
            qs  = (in_word.lane[l].ovf || in_word.lane[l].quo > lim) ? lim
                                                                     : in_word.lane[l].quo;
            if (!in_word.lane[l].nz)
            begin
                t1_next[l] = '0;
            end
            else
            begin
                t1_next[l] = in_word.lane[l].neg ? -qs : qs;
            end
        end
    end

    // per-axis ordering; a parallel axis imposes no limit
    always_comb
    begin
        for (int i = 0; i < rbs_pkg::AXES; i++)
        begin
            if (side1_reg.par[i])
            begin
                n2_next[i] = rbs_pkg::T_MIN;
                f2_next[i] = rbs_pkg::T_MAX;
            end
            else if ($signed(t1_reg[2*i]) > $signed(t1_reg[2*i+1]))
            begin
                n2_next[i] = t1_reg[2*i+1];
                f2_next[i] = t1_reg[2*i];
            end
            else
            begin
                n2_next[i] = t1_reg[2*i];
                f2_next[i] = t1_reg[2*i+1];
            end
        end
    end

    always_comb
    begin
        n3_next = n2_reg[0];
        f3_next = f2_reg[0];
        for (int i = 1; i < rbs_pkg::AXES; i++)
        begin
            if ($signed(n2_reg[i]) > $signed(n3_next))
            begin
                n3_next = n2_reg[i];
            end
            if ($signed(f2_reg[i]) < $signed(f3_next))
            begin
                f3_next = f2_reg[i];
            end
        end
    end

    always_comb
    begin
        if (side3_reg.empty)
        begin
            cause_next = rbs_pkg::MC_EMPTY;
        end
        else if (|side3_reg.par_out)
        begin
            cause_next = rbs_pkg::MC_PARALLEL;
        end
        else if ($signed(n3_reg) > $signed(f3_reg))
        begin
            cause_next = rbs_pkg::MC_DISJOINT;
        end
        else if (f3_reg[rbs_pkg::COORD_W-1])
        begin
            cause_next = rbs_pkg::MC_BEHIND;
        end
        else
        begin
            cause_next = rbs_pkg::MC_HIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            t1_reg    <= t1_next;
            side1_reg <= in_word.side;
        end
        if (v1_reg && rdy2)
        begin
            n2_reg    <= n2_next;
            f2_reg    <= f2_next;
            side2_reg <= side1_reg;
        end
        if (v2_reg && rdy3)
        begin
            n3_reg    <= n3_next;
            f3_reg    <= f3_next;
            side3_reg <= side2_reg;
        end
        if (v3_reg && rdy4)
        begin
            hit_reg   <= (cause_next == rbs_pkg::MC_HIT);
            cause_reg <= cause_next;
            enter_reg <= (cause_next == rbs_pkg::MC_HIT) ? n3_reg : '0;
            exit_reg  <= (cause_next == rbs_pkg::MC_HIT) ? f3_reg : '0;
        end
    end

    assign out_valid      = v4_reg;
    assign hit            = hit_reg;
    assign miss_cause     = cause_reg;
    assign enter_distance = enter_reg;
    assign exit_distance  = exit_reg;

endmodule
`default_nettype wire
